// File: rtl/core/median_fire_detector_defines.svh
// Assertion macros for the median fire detector RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MEDIAN_FIRE_DETECTOR_DEFINES_SVH
`define MEDIAN_FIRE_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// Check sampled on the rising clock edge, ignored while reset is high.
`define MFD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("median fire detector check failed");

// Check sampled on the rising clock edge, also during reset.
`define MFD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("median fire detector check failed");

`else

`define MFD_ASSERT(label, clk, rst, prop)

`define MFD_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// File: rtl/core/mfd_pkg.sv
// Shared constants and types for the median fire detector.
// Used by mfd_median5 and median_fire_detector; depends on nothing.
`default_nettype none

package mfd_pkg;

   localparam int BATCH_LEN   = 35;
   localparam int WINDOW_LEN  = 5;
   localparam int TEMP_W      = 16;
   localparam int COUNT_W     = 5;
   localparam int RISE_W      = TEMP_W + 1;
   localparam int LIMIT_W     = 16;
   localparam int POS_W       = $clog2(BATCH_LEN);
   localparam int RANK_W      = $clog2(WINDOW_LEN);
   localparam int MEDIAN_RANK = WINDOW_LEN / 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [COUNT_W-1:0] HIGH_COUNT_MAX = '1;

   localparam logic signed [TEMP_W-1:0] FIXED_THRESHOLD_RST = 16'sd58;
   localparam logic [COUNT_W-1:0]       COUNT_NEEDED_RST    = 5'd27;
   localparam logic [LIMIT_W-1:0]       RISE_LIMIT_RST      = 16'd8;

   typedef logic signed [TEMP_W-1:0] sample_type;
   typedef sample_type [WINDOW_LEN-1:0] window_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIXED_THRESHOLD = 2'd0,
      CSR_COUNT_NEEDED    = 2'd1,
      CSR_RISE_LIMIT      = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

// File: rtl/core/mfd_median5.sv
// Median of the sample window, found by ranking every sample against the others.
// Depends on mfd_pkg for the window type and sizes.
`default_nettype none

module mfd_median5
   import mfd_pkg::*;
(
   input  window_type window,
   output sample_type median
);

   logic [RANK_W-1:0] rank [WINDOW_LEN];

   // Rank = number of samples that sort before this one; ties break by position,
   // so the ranks form a permutation and exactly one sample has the middle rank.
   always_comb begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WINDOW_LEN; j++) begin
            if (j != i) begin
               if ((window[j] < window[i]) || ((window[j] == window[i]) && (j < i))) begin
                  rank[i] = rank[i] + RANK_W'(1);
               end
            end
         end
      end
   end

   always_comb begin
      median = '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         if (rank[i] == RANK_W'(MEDIAN_RANK)) begin
            median = median | window[i];
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/median_fire_detector.sv
// Median-of-five fire detector: window, batch counter, verdict and output register.
// Depends on mfd_pkg, mfd_median5 and median_fire_detector_defines.svh.
//
// Usage:
//   req_* carries one 16-bit signed temperature sample per transfer; rsp_* carries
//   one verdict (alarm, high_count, rise) per batch of 35 samples. A transfer
//   happens on a rising clock edge with valid high and stall low.
//   Throughput is one sample per cycle while req_stall is low. The window median is
//   registered into the median stage at the edge of the sample transfer, and the batch
//   totals and verdict go from there into the output register that drives rsp_valid.
//   A verdict waits in the output register while rsp_stall is high and samples
//   keep flowing; only when the next verdict is ready behind a stalled one does
//   req_stall go high, until the waiting verdict is taken.
//   Reset (synchronous, active high) empties the pipeline, starts a new batch and
//   loads threshold 58, count needed 27 and rise limit 8.
//   csr_* writes a register and is meant for use while idle:
//   index 0 threshold, 1 count needed, 2 rise limit; index 3 is ignored.
`default_nettype none

module median_fire_detector
   import mfd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [TEMP_W-1:0]   req_temperature,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_alarm,
   output logic [COUNT_W-1:0]         rsp_high_count,
   output logic signed [RISE_W-1:0]   rsp_rise,

   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

`include "median_fire_detector_defines.svh"

   // configuration
   logic signed [TEMP_W-1:0] threshold_ff;
   logic [COUNT_W-1:0]       needed_ff;
   logic [LIMIT_W-1:0]       limit_ff;

   // window stage
   window_type               window_ff;
   logic [POS_W-1:0]         pos_ff;
   sample_type               median;

   // median stage
   logic                     a_vld_ff;
   sample_type               med_ff;
   logic                     a_has_med_ff;
   logic                     a_first_ff;
   logic                     a_last_ff;

   // batch totals
   logic [COUNT_W-1:0]       count_ff;
   sample_type               first_ff;
   sample_type               latest_ff;

   // output register
   logic                     rsp_valid_ff;
   logic                     rsp_alarm_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic signed [RISE_W-1:0] rsp_rise_ff;

   logic                     req_fire;
   logic                     b_block;
   logic                     b_fire;
   logic                     is_high;
   logic [COUNT_W-1:0]       count_in;
   sample_type               first_in;
   sample_type               latest_in;
   logic signed [RISE_W-1:0] rise_in;
   logic                     alarm_in;

   mfd_median5 u_median (
      .window (window_ff),
      .median (median)
   );

   // A verdict cannot enter the output register while the previous one is stalled.
   assign b_block   = a_vld_ff && a_last_ff && rsp_valid_ff && rsp_stall;
   assign b_fire    = a_vld_ff && !b_block;
   assign req_stall = b_block;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      is_high   = med_ff >= threshold_ff;
      count_in  = count_ff;
      first_in  = first_ff;
      latest_in = latest_ff;
      if (a_has_med_ff) begin
         if (is_high && (count_ff != HIGH_COUNT_MAX)) begin
            count_in = count_ff + COUNT_W'(1);
         end
         if (a_first_ff) begin
            first_in = med_ff;
         end
         latest_in = med_ff;
      end
      rise_in  = $signed({latest_in[TEMP_W-1], latest_in}) -
                 $signed({first_in[TEMP_W-1], first_in});
      alarm_in = (count_in >= needed_ff) || (rise_in > $signed({1'b0, limit_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= FIXED_THRESHOLD_RST;
         needed_ff    <= COUNT_NEEDED_RST;
         limit_ff     <= RISE_LIMIT_RST;
         window_ff    <= '0;
         pos_ff       <= '0;
         a_vld_ff     <= 1'b0;
         a_has_med_ff <= 1'b0;
         a_first_ff   <= 1'b0;
         a_last_ff    <= 1'b0;
         count_ff     <= '0;
         first_ff     <= '0;
         latest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FIXED_THRESHOLD: threshold_ff <= $signed(csr_wdata[TEMP_W-1:0]);
               CSR_COUNT_NEEDED:    needed_ff    <= csr_wdata[COUNT_W-1:0];
               CSR_RISE_LIMIT:      limit_ff     <= csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end

         // shift the sample in; the median taken at this edge is of the window before it
         if (req_fire) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
               window_ff[i] <= window_ff[i+1];
            end
            window_ff[WINDOW_LEN-1] <= req_temperature;
            if (pos_ff == POS_W'(BATCH_LEN - 1)) begin
               pos_ff <= '0;
            end else begin
               pos_ff <= pos_ff + POS_W'(1);
            end
         end

         if (!b_block) begin
            a_vld_ff     <= req_fire;
            med_ff       <= median;
            a_has_med_ff <= pos_ff >= POS_W'(WINDOW_LEN);
            a_first_ff   <= pos_ff == POS_W'(WINDOW_LEN);
            a_last_ff    <= pos_ff == POS_W'(BATCH_LEN - 1);
         end

         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (b_fire) begin
            if (a_last_ff) begin
               count_ff     <= '0;
               first_ff     <= '0;
               latest_ff    <= '0;
               rsp_valid_ff <= 1'b1;
               rsp_alarm_ff <= alarm_in;
               rsp_count_ff <= count_in;
               rsp_rise_ff  <= rise_in;
            end else begin
               count_ff  <= count_in;
               first_ff  <= first_in;
               latest_ff <= latest_in;
            end
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alarm      = rsp_alarm_ff;
   assign rsp_high_count = rsp_count_ff;
   assign rsp_rise       = rsp_rise_ff;

   `MFD_ASSERT(a_pos_wrap, clock, reset,
      (req_fire && (pos_ff == POS_W'(BATCH_LEN - 1))) |=> (pos_ff == '0))
   `MFD_ASSERT(a_verdict_source, clock, reset, $rose(rsp_valid_ff) |-> $past(a_vld_ff && a_last_ff))
   `MFD_ASSERT(a_last_has_median, clock, reset, (a_vld_ff && a_last_ff) |-> a_has_med_ff)
   `MFD_ASSERT(a_totals_cleared, clock, reset,
      (b_fire && a_last_ff) |=> ((count_ff == '0) && (first_ff == '0) && (latest_ff == '0)))
   `MFD_ASSERT_ALWAYS(a_reset_empties, clock,
      reset |=> (!rsp_valid_ff && !a_vld_ff && (pos_ff == '0)))

endmodule

`default_nettype wire
